// ===== src/fbp_pkg.sv =====
package fbp_pkg;

  // Field widths of the request, response and configuration ports
  localparam int ACTION_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int TOTAL_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int READERS_W = 8;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_WRITING = 2'd1,
    ST_READING = 2'd2
  } entry_state_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK       = 3'd0,
    RS_NOFREE   = 3'd1,
    RS_STATE    = 3'd2,
    RS_INDEX    = 3'd3,
    RS_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQ_WRITE   = 3'd0,
    ACT_PUBLISH     = 3'd1,
    ACT_ACQ_CURRENT = 3'd2,
    ACT_JOIN        = 3'd3,
    ACT_RELEASE     = 3'd4
  } action_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MOD,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_DONE
  } fsm_t;

  // Width of the shared ALU: pool count, size register and reader count all fit
  function automatic int alu_width(input int mb, input int rb);
    int nw;
    int cw;
    nw = $clog2(mb + 1);
    cw = (nw > CFG_W) ? nw : CFG_W;
    return (cw > rb) ? cw : rb;
  endfunction

endpackage

// ===== src/fbp_req_if.sv =====
interface fbp_req_if;
  import fbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  buffer_index;
  logic [TOTAL_W-1:0]  reader_total;

  modport source (output valid, output action, output buffer_index, output reader_total,
                  input ready);
  modport sink   (input valid, input action, input buffer_index, input reader_total,
                  output ready);
endinterface

// ===== src/fbp_rsp_if.sv =====
interface fbp_rsp_if;
  import fbp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [INDEX_W-1:0]   granted_index;
  logic [STATUS_W-1:0]  status;
  logic [READERS_W-1:0] readers_after;

  modport source (output valid, output granted_index, output status, output readers_after,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input readers_after,
                  output ready);
endinterface

// ===== src/fbp_alu.sv =====
// Shared add/subtract unit: start index, modulo reduction, scan step,
// reader count increment and decrement all go through here.
module fbp_alu #(
  parameter int W = 8
) (
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  fbp_pkg::alu_op_t op,
  output logic [W-1:0]     res,
  output logic             ge
);
  import fbp_pkg::*;

  logic [W:0] sum;

  // a + b, or a + ~b + 1; carry out of the subtract means a >= b
  always_comb begin
    if (op == ALU_SUB) begin
      sum = {1'b0, a} + {1'b0, ~b} + (W+1)'(1);
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
  end

  assign res = sum[W-1:0];
  assign ge  = sum[W];
endmodule

// ===== src/fbp_entry_ram.sv =====
// Entry store: state and reader count per buffer, one write and one
// registered read port. Per-entry valid flags make unwritten entries read
// as free with no readers straight after reset.
module fbp_entry_ram #(
  parameter int DEPTH = 16,
  parameter int RW    = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_state,
  input  logic [RW-1:0]            wr_readers,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [1:0]               rd_state,
  output logic [RW-1:0]            rd_readers
);
  import fbp_pkg::*;

  logic [RW+1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [RW+1:0]    rd_q;
  logic             rd_vld;

  // data array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_state, wr_readers};
    end
    rd_q <= mem[rd_addr];
  end

  // written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_state   = rd_vld ? rd_q[RW+1:RW] : ST_FREE;
  assign rd_readers = rd_vld ? rd_q[RW-1:0]  : '0;
endmodule

// ===== src/fbp_seq.sv =====
// Request sequencer: takes one request, runs the scan or the single-entry
// update through the entry store and the shared ALU, then holds the result
// in the response register.
module fbp_seq #(
  parameter int MAX_BUFFERS = 16,
  parameter int READER_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  fbp_req_if.sink                                req,
  fbp_rsp_if.source                              rsp,
  input  logic [$clog2(MAX_BUFFERS+1)-1:0]       pool_n,
  output logic [$clog2(MAX_BUFFERS)-1:0]         ram_wr_addr,
  output logic                                   ram_wr_en,
  output logic [1:0]                             ram_wr_state,
  output logic [READER_BITS-1:0]                 ram_wr_readers,
  output logic [$clog2(MAX_BUFFERS)-1:0]         ram_rd_addr,
  input  logic [1:0]                             ram_rd_state,
  input  logic [READER_BITS-1:0]                 ram_rd_readers,
  output logic [fbp_pkg::alu_width(MAX_BUFFERS, READER_BITS)-1:0] alu_a,
  output logic [fbp_pkg::alu_width(MAX_BUFFERS, READER_BITS)-1:0] alu_b,
  output fbp_pkg::alu_op_t                       alu_op,
  input  logic [fbp_pkg::alu_width(MAX_BUFFERS, READER_BITS)-1:0] alu_res,
  input  logic                                   alu_ge
);
  import fbp_pkg::*;

  localparam int IW = $clog2(MAX_BUFFERS);
  localparam int NW = $clog2(MAX_BUFFERS + 1);
  localparam int RW = READER_BITS;
  localparam int UW = alu_width(MAX_BUFFERS, READER_BITS);
  localparam int GW = (IW > INDEX_W) ? IW : INDEX_W;
  localparam int TW = (RW > TOTAL_W) ? RW : TOTAL_W;
  localparam logic [RW-1:0] RMAX = '1;

  function automatic logic [INDEX_W-1:0] to_gi(input logic [IW-1:0] i);
    logic [GW-1:0] w;
    w = GW'(i);
    return w[INDEX_W-1:0];
  endfunction

  function automatic logic [READERS_W-1:0] to_rd(input logic [RW-1:0] r);
    logic [TW-1:0] w;
    w = TW'(r);
    return w[READERS_W-1:0];
  endfunction

  fsm_t                 state, state_next;
  logic [ACTION_W-1:0]  act;
  logic [INDEX_W-1:0]   bi;
  logic [TOTAL_W-1:0]   total;
  logic [IW-1:0]        cur, cur_next;
  logic [UW-1:0]        ptr, ptr_next;
  logic [NW-1:0]        issued, issued_next;
  logic                 pend, pend_next;
  logic [IW-1:0]        pend_idx, pend_idx_next;
  logic [INDEX_W-1:0]   res_gi, res_gi_next;
  status_t              res_st, res_st_next;
  logic [READERS_W-1:0] res_rd, res_rd_next;
  logic                 out_valid;
  logic [INDEX_W-1:0]   out_gi;
  status_t              out_st;
  logic [READERS_W-1:0] out_rd;

  logic                 accept;
  logic                 slot_free;
  logic                 hit;
  logic                 scan_end;
  logic [UW-1:0]        n_u;
  logic [UW-1:0]        bi_u;
  logic [UW-1:0]        cur_u;
  logic [GW-1:0]        bi_g;
  logic [IW-1:0]        tgt;
  logic [TW-1:0]        tot_t;
  logic                 tot_ovf;
  logic                 rd_full;
  logic [RW-1:0]        alu_rd;
  entry_state_t         rd_st;

  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign rd_st     = entry_state_t'(ram_rd_state);
  assign hit       = pend && (rd_st == ST_FREE);
  assign scan_end  = (issued == pool_n);
  assign n_u       = UW'(pool_n);
  assign bi_u      = UW'(bi);
  assign cur_u     = UW'(cur);
  assign bi_g      = GW'(bi);
  assign tgt       = bi_g[IW-1:0];
  assign tot_t     = TW'(total);
  assign tot_ovf   = tot_t > TW'(RMAX);
  assign rd_full   = (ram_rd_readers == RMAX);
  assign alu_rd    = alu_res[RW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (action_t'(req.action) == ACT_ACQ_WRITE) ? S_START : S_READ;
        end
      end
      S_START: state_next = S_MOD;
      S_MOD: begin
        if (!alu_ge) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_next = S_DONE;
        end
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: state_next = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    alu_a          = '0;
    alu_b          = '0;
    alu_op         = ALU_ADD;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = tgt;
    ram_wr_state   = ST_FREE;
    ram_wr_readers = ram_rd_readers;
    ram_rd_addr    = tgt;
    cur_next       = cur;
    ptr_next       = ptr;
    issued_next    = issued;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    res_gi_next    = res_gi;
    res_st_next    = res_st;
    res_rd_next    = res_rd;
    case (state)
      S_IDLE: begin
        issued_next = '0;
        pend_next   = 1'b0;
      end
      // start index is current + 1
      S_START: begin
        alu_a    = cur_u;
        alu_b    = UW'(1);
        ptr_next = alu_res;
      end
      // reduce the start index modulo the pool size
      S_MOD: begin
        alu_a  = ptr;
        alu_b  = n_u;
        alu_op = ALU_SUB;
        if (alu_ge) begin
          ptr_next = alu_res;
        end
      end
      // one entry read per cycle; the previous read is checked meanwhile
      S_SCAN: begin
        alu_a       = ptr;
        alu_b       = UW'(1);
        ram_rd_addr = ptr[IW-1:0];
        if (hit) begin
          ram_wr_en    = 1'b1;
          ram_wr_addr  = pend_idx;
          ram_wr_state = ST_WRITING;
          res_gi_next  = to_gi(pend_idx);
          res_st_next  = RS_OK;
          res_rd_next  = to_rd(ram_rd_readers);
        end else if (scan_end) begin
          res_gi_next = to_gi(cur);
          res_st_next = RS_NOFREE;
          res_rd_next = '0;
        end else begin
          pend_next     = 1'b1;
          pend_idx_next = ptr[IW-1:0];
          ptr_next      = (alu_res == n_u) ? '0 : alu_res;
          issued_next   = issued + NW'(1);
        end
      end
      S_READ: begin
        ram_rd_addr = (action_t'(act) == ACT_ACQ_CURRENT) ? cur : tgt;
      end
      // single-entry update on the entry read in the previous cycle
      S_EXEC: begin
        alu_a       = UW'(ram_rd_readers);
        alu_b       = UW'(1);
        alu_op      = (action_t'(act) == ACT_RELEASE) ? ALU_SUB : ALU_ADD;
        res_gi_next = bi;
        res_rd_next = to_rd(ram_rd_readers);
        case (action_t'(act))
          ACT_PUBLISH: begin
            if (bi_u >= n_u) begin
              res_st_next = RS_INDEX;
              res_rd_next = '0;
            end else if (rd_st != ST_WRITING) begin
              res_st_next = RS_STATE;
            end else if (tot_ovf) begin
              res_st_next = RS_OVERFLOW;
            end else begin
              ram_wr_en      = 1'b1;
              ram_wr_state   = (total != '0) ? ST_READING : ST_FREE;
              ram_wr_readers = tot_t[RW-1:0];
              cur_next       = tgt;
              res_st_next    = RS_OK;
              res_rd_next    = total;
            end
          end
          ACT_ACQ_CURRENT: begin
            res_gi_next = to_gi(cur);
            ram_wr_addr = cur;
            if (cur_u >= n_u) begin
              res_st_next = RS_INDEX;
              res_rd_next = '0;
            end else if (rd_st != ST_FREE && rd_st != ST_READING) begin
              res_st_next = RS_STATE;
            end else if (rd_full) begin
              res_st_next = RS_OVERFLOW;
            end else begin
              ram_wr_en      = 1'b1;
              ram_wr_state   = ST_READING;
              ram_wr_readers = alu_rd;
              res_st_next    = RS_OK;
              res_rd_next    = to_rd(alu_rd);
            end
          end
          ACT_JOIN: begin
            if (bi_u >= n_u) begin
              res_st_next = RS_INDEX;
              res_rd_next = '0;
            end else if (rd_st != ST_READING) begin
              res_st_next = RS_STATE;
            end else if (rd_full) begin
              res_st_next = RS_OVERFLOW;
            end else begin
              ram_wr_en      = 1'b1;
              ram_wr_state   = ST_READING;
              ram_wr_readers = alu_rd;
              res_st_next    = RS_OK;
              res_rd_next    = to_rd(alu_rd);
            end
          end
          ACT_RELEASE: begin
            if (bi_u >= n_u) begin
              res_st_next = RS_INDEX;
              res_rd_next = '0;
            end else if (ram_rd_readers == '0) begin
              res_st_next = RS_STATE;
              res_rd_next = '0;
            end else begin
              ram_wr_en      = 1'b1;
              ram_wr_state   = (alu_rd == '0) ? ST_FREE : ram_rd_state;
              ram_wr_readers = alu_rd;
              res_st_next    = RS_OK;
              res_rd_next    = to_rd(alu_rd);
            end
          end
          default: begin
            // unknown action: nothing changes
            res_gi_next = to_gi(cur);
            res_st_next = RS_STATE;
            res_rd_next = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= req.action;
      bi    <= req.buffer_index;
      total <= req.reader_total;
    end
    ptr      <= ptr_next;
    issued   <= issued_next;
    pend     <= pend_next;
    pend_idx <= pend_idx_next;
    res_gi   <= res_gi_next;
    res_st   <= res_st_next;
    res_rd   <= res_rd_next;
    if (state == S_DONE && slot_free) begin
      out_gi <= res_gi;
      out_st <= res_st;
      out_rd <= res_rd;
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.granted_index = out_gi;
  assign rsp.status        = out_st;
  assign rsp.readers_after = out_rd;

  // the store is only written from the scan or the update step
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == S_SCAN || state == S_EXEC))
    else $error("entry write outside scan or update");

  // the scan never reads more entries than the pool holds
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issued <= pool_n))
    else $error("scan ran past the pool");

  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE && !req.ready))
    else $error("request accepted but sequencer idle");

  // a finished result reaches the response register
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("result not presented");

endmodule

// ===== src/frame_buffer_pool_manager_top.sv =====
// Frame buffer pool manager. One request at a time; the next is taken the cycle after the
// result is registered. Publish, join, release and acquire-current: S_READ reads the entry,
// S_EXEC updates it and S_DONE registers the result. Acquire write: S_START forms current+1,
// S_MOD subtracts n until it is below n, then S_SCAN reads one entry per cycle from the entry
// store port until a free entry is found or n are read (n buffers in use). Synchronous reset:
// all buffers free, no readers, current index 0, 16 buffers in use.
module frame_buffer_pool_manager_top #(
  parameter int MAX_BUFFERS = 16,
  parameter int READER_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  fbp_req_if.sink                   req,
  fbp_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [fbp_pkg::CFG_W-1:0] cfg_wdata
);
  import fbp_pkg::*;

  localparam int IW = $clog2(MAX_BUFFERS);
  localparam int NW = $clog2(MAX_BUFFERS + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;
  localparam int RW = READER_BITS;
  localparam int UW = (CW > RW) ? CW : RW;

  logic [CFG_W-1:0] buffers_in_use;
  logic [CW-1:0]    cfg_u;
  logic [CW-1:0]    n_c;
  logic [NW-1:0]    pool_n;

  logic [IW-1:0]    wr_addr, rd_addr;
  logic             wr_en;
  logic [1:0]       wr_state, rd_state;
  logic [RW-1:0]    wr_readers, rd_readers;
  logic [UW-1:0]    alu_a, alu_b, alu_res;
  alu_op_t          alu_op;
  logic             alu_ge;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffers_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      buffers_in_use <= cfg_wdata;
    end
  end

  // effective pool size, limited to 1..MAX_BUFFERS
  assign cfg_u = CW'(buffers_in_use);
  always_comb begin
    if (cfg_u == '0) begin
      n_c = CW'(1);
    end else if (cfg_u > CW'(MAX_BUFFERS)) begin
      n_c = CW'(MAX_BUFFERS);
    end else begin
      n_c = cfg_u;
    end
  end
  assign pool_n = n_c[NW-1:0];

  fbp_seq #(
    .MAX_BUFFERS (MAX_BUFFERS),
    .READER_BITS (READER_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .pool_n         (pool_n),
    .ram_wr_addr    (wr_addr),
    .ram_wr_en      (wr_en),
    .ram_wr_state   (wr_state),
    .ram_wr_readers (wr_readers),
    .ram_rd_addr    (rd_addr),
    .ram_rd_state   (rd_state),
    .ram_rd_readers (rd_readers),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_op         (alu_op),
    .alu_res        (alu_res),
    .alu_ge         (alu_ge)
  );

  fbp_entry_ram #(
    .DEPTH (MAX_BUFFERS),
    .RW    (READER_BITS)
  ) u_ram (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_state   (wr_state),
    .wr_readers (wr_readers),
    .rd_addr    (rd_addr),
    .rd_state   (rd_state),
    .rd_readers (rd_readers)
  );

  fbp_alu #(
    .W (UW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res),
    .ge  (alu_ge)
  );

endmodule

// ===== bench/frame_buffer_pool_manager_top_test.sv =====
module frame_buffer_pool_manager_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbp_pkg::*;

  localparam int POOL_MAX        = 16;
  localparam int READER_LIMIT    = (1 << READERS_W) - 1;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PHASES          = 8;
  localparam int SETTLE_CYCLES   = 2 * POOL_MAX + 8;
  localparam int HOLD_AT_RESULT  = 100;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 500000;

  // Action codes outside the defined set
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;

  typedef struct {
    logic [INDEX_W-1:0]   granted;
    status_t              status;
    logic [READERS_W-1:0] readers;
  } grant_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_W-1:0]     cfg_value;
    logic [ACTION_W-1:0]  action;
    logic [INDEX_W-1:0]   idx;
    logic [TOTAL_W-1:0]   total;
    bit                   typed;
    grant_t               want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  fbp_req_if req_bus ();
  fbp_rsp_if rsp_bus ();

  frame_buffer_pool_manager_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Pool model: entry states, reader counts, current entry, size register
  entry_state_t         pool_state   [POOL_MAX];
  logic [READERS_W-1:0] pool_readers [POOL_MAX];
  logic [INDEX_W-1:0]   cur_idx;
  logic [CFG_W-1:0]     pool_size_reg;

  grant_t grants_due [$];
  int     failures;
  int     cycles;
  int     send_idle_pct;
  int     rsp_stall_pct;
  logic [CFG_W-1:0] phase_sizes [PHASES];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("mismatch: %s", what);
  endtask

  function automatic int pool_count();
    if (pool_size_reg == 0) return 1;
    if (pool_size_reg > POOL_MAX) return POOL_MAX;
    return int'(pool_size_reg);
  endfunction

  // Works out the grant for one request and updates the pool model
  function automatic grant_t predict_grant(input logic [ACTION_W-1:0] act,
                                           input logic [INDEX_W-1:0] bi,
                                           input logic [TOTAL_W-1:0] total);
    grant_t g;
    int n;
    int k;
    int slot;
    bit found;
    n = pool_count();
    g.granted = cur_idx;
    g.status  = RS_STATE;
    g.readers = '0;
    case (act)
      ACT_ACQ_WRITE: begin
        // round-robin scan from the entry after the current one
        found    = 1'b0;
        g.status = RS_NOFREE;
        for (k = 1; k <= n && !found; k++) begin
          slot = (int'(cur_idx) + k) % n;
          if (pool_state[slot] == ST_FREE) begin
            pool_state[slot] = ST_WRITING;
            found     = 1'b1;
            g.granted = INDEX_W'(slot);
            g.status  = RS_OK;
            g.readers = pool_readers[slot];
          end
        end
      end
      ACT_PUBLISH: begin
        g.granted = bi;
        if (bi >= n) begin
          g.status = RS_INDEX;
        end else if (pool_state[bi] != ST_WRITING) begin
          g.status  = RS_STATE;
          g.readers = pool_readers[bi];
        end else begin
          pool_state[bi]   = (total != 0) ? ST_READING : ST_FREE;
          pool_readers[bi] = total;
          cur_idx   = bi;
          g.status  = RS_OK;
          g.readers = total;
        end
      end
      ACT_ACQ_CURRENT: begin
        g.granted = cur_idx;
        if (cur_idx >= n) begin
          g.status = RS_INDEX;
        end else if (pool_state[cur_idx] != ST_FREE && pool_state[cur_idx] != ST_READING) begin
          g.status  = RS_STATE;
          g.readers = pool_readers[cur_idx];
        end else if (pool_readers[cur_idx] >= READER_LIMIT) begin
          g.status  = RS_OVERFLOW;
          g.readers = pool_readers[cur_idx];
        end else begin
          pool_state[cur_idx]   = ST_READING;
          pool_readers[cur_idx] = pool_readers[cur_idx] + 1'b1;
          g.status  = RS_OK;
          g.readers = pool_readers[cur_idx];
        end
      end
      ACT_JOIN: begin
        g.granted = bi;
        if (bi >= n) begin
          g.status = RS_INDEX;
        end else if (pool_state[bi] != ST_READING) begin
          g.status  = RS_STATE;
          g.readers = pool_readers[bi];
        end else if (pool_readers[bi] >= READER_LIMIT) begin
          g.status  = RS_OVERFLOW;
          g.readers = pool_readers[bi];
        end else begin
          pool_readers[bi] = pool_readers[bi] + 1'b1;
          g.status  = RS_OK;
          g.readers = pool_readers[bi];
        end
      end
      ACT_RELEASE: begin
        g.granted = bi;
        if (bi >= n) begin
          g.status = RS_INDEX;
        end else if (pool_readers[bi] == 0) begin
          g.status = RS_STATE;
        end else begin
          pool_readers[bi] = pool_readers[bi] - 1'b1;
          if (pool_readers[bi] == 0) pool_state[bi] = ST_FREE;
          g.status  = RS_OK;
          g.readers = pool_readers[bi];
        end
      end
      default: begin
        // unknown action: current index, wrong state, nothing changes
      end
    endcase
    return g;
  endfunction

  // Random entry in the wanted state, now and then any index at all
  function automatic logic [INDEX_W-1:0] pick_entry(input entry_state_t want);
    int hits [$];
    int n;
    int i;
    n = pool_count();
    for (i = 0; i < n; i++) begin
      if (pool_state[i] == want) hits.push_back(i);
    end
    if (hits.size() == 0 || $urandom_range(9) == 0) return INDEX_W'($urandom_range(POOL_MAX - 1));
    return INDEX_W'(hits[$urandom_range(hits.size() - 1)]);
  endfunction

  function automatic plan_row_t req_row(input logic [ACTION_W-1:0] act,
                                        input logic [INDEX_W-1:0] bi,
                                        input logic [TOTAL_W-1:0] total,
                                        input bit typed = 1'b0,
                                        input logic [INDEX_W-1:0] g = '0,
                                        input status_t s = RS_OK,
                                        input logic [READERS_W-1:0] rd = '0);
    plan_row_t r;
    r.is_cfg       = 1'b0;
    r.cfg_value    = '0;
    r.action       = act;
    r.idx          = bi;
    r.total        = total;
    r.typed        = typed;
    r.want.granted = g;
    r.want.status  = s;
    r.want.readers = rd;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] v);
    plan_row_t r;
    r        = req_row(ACT_ACQ_WRITE, '0, '0);
    r.is_cfg = 1'b1;
    r.cfg_value = v;
    return r;
  endfunction

  // One request transfer; the grant is predicted at the accepting edge
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [INDEX_W-1:0] bi,
                              input logic [TOTAL_W-1:0] total,
                              input bit typed,
                              input grant_t want);
    grant_t g;
    if ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_bus.valid        <= 1'b1;
    req_bus.action       <= act;
    req_bus.buffer_index <= bi;
    req_bus.reader_total <= total;
    do @(posedge clk); while (!req_bus.ready);
    g = predict_grant(act, bi, total);
    grants_due.push_back(typed ? want : g);
  endtask

  // Size register write, only once the block has gone idle
  task automatic write_pool_size(input logic [CFG_W-1:0] v);
    req_bus.valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= v;
    pool_size_reg  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Response side: ready pattern, one long hold-off, result checking
  initial begin
    grant_t due;
    int results_seen;
    int hold_left;
    bit hold_done;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen++;
        if (grants_due.size() == 0) begin
          report_failure($sformatf("result idx %0d status %0d readers %0d with nothing pending",
                                   rsp_bus.granted_index, rsp_bus.status,
                                   rsp_bus.readers_after));
        end else begin
          due = grants_due.pop_front();
          if (rsp_bus.granted_index !== due.granted || rsp_bus.status !== due.status ||
              rsp_bus.readers_after !== due.readers) begin
            report_failure($sformatf(
              "expected idx %0d status %0d readers %0d, got idx %0d status %0d readers %0d",
              due.granted, due.status, due.readers, rsp_bus.granted_index,
              rsp_bus.status, rsp_bus.readers_after));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Request side: directed table, then random phases
  initial begin
    plan_row_t plan [$];
    grant_t blank;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  bi;
    logic [TOTAL_W-1:0]  total;
    int i;
    int p;
    int r;
    int q;

    failures      = 0;
    cycles        = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    blank         = '{granted: '0, status: RS_OK, readers: '0};
    phase_sizes   = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd2, 5'd9, 5'd16};
    for (i = 0; i < POOL_MAX; i++) begin
      pool_state[i]   = ST_FREE;
      pool_readers[i] = '0;
    end
    cur_idx       = '0;
    pool_size_reg = CFG_RESET;

    req_bus.valid        <= 1'b0;
    req_bus.action       <= ACT_ACQ_WRITE;
    req_bus.buffer_index <= '0;
    req_bus.reader_total <= '0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= CFG_RESET;
    rst                  <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table: fresh pool, reader limit, wrong states, unknown actions
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd0,  8'd0,   1, 4'd1,  RS_OK,       8'd0));
    plan.push_back(req_row(ACT_PUBLISH,     4'd1,  8'd255, 1, 4'd1,  RS_OK,       8'd255));
    plan.push_back(req_row(ACT_ACQ_CURRENT, 4'd0,  8'd0,   1, 4'd1,  RS_OVERFLOW, 8'd255));
    plan.push_back(req_row(ACT_JOIN,        4'd1,  8'd0,   1, 4'd1,  RS_OVERFLOW, 8'd255));
    plan.push_back(req_row(ACT_RELEASE,     4'd1,  8'd0,   1, 4'd1,  RS_OK,       8'd254));
    plan.push_back(req_row(ACT_JOIN,        4'd1,  8'd0,   1, 4'd1,  RS_OK,       8'd255));
    plan.push_back(req_row(ACT_PUBLISH,     4'd1,  8'd7,   1, 4'd1,  RS_STATE,    8'd255));
    plan.push_back(req_row(ACT_PUBLISH,     4'd15, 8'd3,   1, 4'd15, RS_STATE,    8'd0));
    plan.push_back(req_row(ACT_JOIN,        4'd15, 8'd0,   1, 4'd15, RS_STATE,    8'd0));
    plan.push_back(req_row(ACT_RELEASE,     4'd0,  8'd0,   1, 4'd0,  RS_STATE,    8'd0));
    plan.push_back(req_row(ACT_UNKNOWN_LO,  4'd15, 8'd255, 1, 4'd1,  RS_STATE,    8'd0));
    plan.push_back(req_row(ACT_UNKNOWN_HI,  4'd0,  8'd0,   1, 4'd1,  RS_STATE,    8'd0));
    // publish with no readers frees the entry, acquire current takes it back
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd9,  8'd0,   1, 4'd2,  RS_OK,       8'd0));
    plan.push_back(req_row(ACT_PUBLISH,     4'd2,  8'd0,   1, 4'd2,  RS_OK,       8'd0));
    plan.push_back(req_row(ACT_ACQ_CURRENT, 4'd0,  8'd0));
    plan.push_back(req_row(ACT_RELEASE,     4'd2,  8'd0));
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd0,  8'd0));
    plan.push_back(req_row(ACT_PUBLISH,     4'd3,  8'd1));
    // shrink the pool under the current index
    plan.push_back(cfg_row(5'd2));
    plan.push_back(req_row(ACT_ACQ_CURRENT, 4'd0,  8'd0,   1, 4'd3,  RS_INDEX,    8'd0));
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd0,  8'd0,   1, 4'd0,  RS_OK,       8'd0));
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd0,  8'd0,   1, 4'd3,  RS_NOFREE,   8'd0));
    plan.push_back(req_row(ACT_PUBLISH,     4'd5,  8'd1,   1, 4'd5,  RS_INDEX,    8'd0));
    plan.push_back(req_row(ACT_RELEASE,     4'd2,  8'd0,   1, 4'd2,  RS_INDEX,    8'd0));
    // zero register means one buffer; acquire current of a writing entry
    plan.push_back(cfg_row(5'd0));
    plan.push_back(req_row(ACT_PUBLISH,     4'd0,  8'd0,   1, 4'd0,  RS_OK,       8'd0));
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd0,  8'd0,   1, 4'd0,  RS_OK,       8'd0));
    plan.push_back(req_row(ACT_ACQ_CURRENT, 4'd0,  8'd0,   1, 4'd0,  RS_STATE,    8'd0));
    // oversized register clamps to the full pool
    plan.push_back(cfg_row(5'd31));
    plan.push_back(req_row(ACT_ACQ_WRITE,   4'd0,  8'd0));

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        write_pool_size(plan[i].cfg_value);
      end else begin
        send_request(plan[i].action, plan[i].idx, plan[i].total, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: pool size and idle pattern change between phases
    for (p = 0; p < PHASES; p++) begin
      write_pool_size(phase_sizes[p]);
      send_idle_pct = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 21 : 0;
      rsp_stall_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 21 : 0;
      repeat (ITEMS_PER_PHASE) begin
        bi    = INDEX_W'($urandom_range(POOL_MAX - 1));
        total = TOTAL_W'($urandom_range(READER_LIMIT));
        r     = $urandom_range(99);
        if (r < 24) begin
          act = ACT_ACQ_WRITE;
        end else if (r < 44) begin
          act = ACT_PUBLISH;
          bi  = pick_entry(ST_WRITING);
          q   = $urandom_range(99);
          // mostly few readers so entries cycle back to free
          if (q < 60) total = TOTAL_W'($urandom_range(3));
          else if (q >= 85) total = TOTAL_W'(READER_LIMIT - $urandom_range(1));
        end else if (r < 56) begin
          act = ACT_ACQ_CURRENT;
        end else if (r < 70) begin
          act = ACT_JOIN;
          bi  = pick_entry(ST_READING);
        end else if (r < 92) begin
          act = ACT_RELEASE;
          bi  = pick_entry(ST_READING);
        end else begin
          act = ACTION_W'($urandom_range(7));
        end
        send_request(act, bi, total, 1'b0, blank);
      end
    end

    // Drain
    req_bus.valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fbp_pkg.sv
src/fbp_req_if.sv
src/fbp_rsp_if.sv
src/fbp_alu.sv
src/fbp_entry_ram.sv
src/fbp_seq.sv
src/frame_buffer_pool_manager_top.sv
bench/frame_buffer_pool_manager_top_test.sv
